>>> rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the serial line editor
// Word formats of both channels, result kinds, and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Default number of slots in the character ring.
  localparam int RING_SLOTS_DEFAULT = 128;

  // Width and ceiling of the reported erase count.
  localparam int ERASE_W = 7;
  localparam logic [ERASE_W-1:0] ERASE_MAX = 7'd127;

  // Request opcodes.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds.
  localparam logic [2:0] KIND_DROP     = 3'd0;
  localparam logic [2:0] KIND_ECHO     = 3'd1;
  localparam logic [2:0] KIND_BELL     = 3'd2;
  localparam logic [2:0] KIND_ERASE    = 3'd3;
  localparam logic [2:0] KIND_NEWLINE  = 3'd4;
  localparam logic [2:0] KIND_DATA     = 3'd5;
  localparam logic [2:0] KIND_NOTREADY = 3'd6;

  // Request word.
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_char;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         out_char;
    logic [ERASE_W-1:0] erase_count;
    logic               line_end;
  } out_word_t;

  // Source of the character field of a result.
  typedef enum logic [1:0] {
    CSEL_ZERO = 2'd0,
    CSEL_IN   = 2'd1,
    CSEL_RD   = 2'd2
  } char_sel_t;

  // Source of the erase count of a result.
  typedef enum logic [1:0] {
    NSEL_ZERO = 2'd0,
    NSEL_ONE  = 2'd1,
    NSEL_CNT  = 2'd2,
    NSEL_LEN  = 2'd3
  } cnt_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_load;
    logic       rd_en;
    logic       rd_prev;
    logic       wr_en;
    logic       wr_lf;
    logic       wp_dec;
    logic       wp_to_rp;
    logic       rp_inc;
    logic       set_ready;
    logic       clear_ready;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       res_load;
    logic [2:0] res_kind;
    char_sel_t  char_sel;
    cnt_sel_t   cnt_sel;
    logic       res_end;
    logic       out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic opcode;
    logic is_cr;
    logic is_bs;
    logic is_werase;
    logic is_kill;
    logic line_ready;
    logic len_zero;
    logic len_one;
    logic full;
    logic rd_white;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/serial_line_editor.sv
// ----------------------------------------------------------------------------
// serial_line_editor: console line editor over a character ring
// Edits a typed line character by character and drains finished lines.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one word per received character (opcode 0)
// or per read request (opcode 1). The rsp channel returns exactly one result
// word for each request word, in order. Both channels use valid and stall.
//
// A plain character, backspace, line kill, carriage return, drop or
// not-ready answer is decoded in S_EXEC and its result then loaded into the
// output register; a read of a line byte passes through S_RDATA as well, for
// the registered read of the line store. A word erase loops once per erased
// character, reading one stored character and testing it before stepping the
// cursor back, until it runs back to the start of the line or stops at
// whitespace. A new request is taken only after the previous result is
// loaded into the output register.
//
// Reset clears the pointers, the line ready flag and the output valid flag;
// the line store itself is not cleared and needs no clearing pass. While the
// receiver stalls, the result stays in the output register and the block can
// take and work on one further request, whose result waits until it is free.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_word_t rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Ring, pointers and result registers.
  sle_datapath #(
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> rtl/core/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath: character ring, pointers and result registers
// Holds the line store, the read and write pointers, the line ready flag,
// the word erase counter, a pending result and the output register.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
  parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  in_word_t   req,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output out_word_t  rsp
);

  localparam int PTR_W = $clog2(RING_SLOTS);
  localparam int LEN_W = PTR_W + 1;
  localparam int SAT_W = (LEN_W > ERASE_W) ? LEN_W : ERASE_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_SLOTS - 1);

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_WERASE = 8'h17;
  localparam logic [7:0] CH_KILL   = 8'h15;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  in_word_t         cur;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] cnt;
  logic             line_ready;
  logic [7:0]       mem [RING_SLOTS];
  logic [7:0]       rd_data;
  out_word_t        res;
  out_word_t        rsp_r;
  logic             rsp_valid_r;

  logic [PTR_W-1:0]   wp_prev;
  logic [PTR_W-1:0]   wp_succ;
  logic [PTR_W-1:0]   rp_succ;
  logic [LEN_W-1:0]   len;
  logic [SAT_W-1:0]   cnt_val;
  logic [ERASE_W-1:0] erase_val;
  logic [7:0]         char_val;

  // Ring neighbors of the pointers, and the current line length.
  always_comb begin
    wp_prev = (wp == '0) ? LAST_SLOT : wp - PTR_W'(1);
    wp_succ = (wp == LAST_SLOT) ? '0 : wp + PTR_W'(1);
    rp_succ = (rp == LAST_SLOT) ? '0 : rp + PTR_W'(1);
    if (wp >= rp) begin
      len = {1'b0, wp} - {1'b0, rp};
    end else begin
      len = {1'b0, wp} + LEN_W'(RING_SLOTS) - {1'b0, rp};
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cur <= req;
    end
  end

  // Pointers and the line ready flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp         <= '0;
      wp         <= '0;
      line_ready <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        wp <= wp_succ;
      end else if (cmd.wp_dec) begin
        wp <= wp_prev;
      end else if (cmd.wp_to_rp) begin
        wp <= rp;
      end
      if (cmd.rp_inc) begin
        rp <= rp_succ;
      end
      if (cmd.set_ready) begin
        line_ready <= 1'b1;
      end else if (cmd.clear_ready) begin
        line_ready <= 1'b0;
      end
    end
  end

  // Line store: one write port at the write pointer.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wp] <= cmd.wr_lf ? CH_LF : cur.rx_char;
    end
  end

  // Line store: registered read at the read pointer or just before the cursor.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_prev ? wp_prev : rp];
    end
  end

  // Word erase counter.
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + PTR_W'(1);
    end
  end

  // Result field selection; counts above the field's range saturate.
  always_comb begin
    case (cmd.cnt_sel)
      NSEL_ZERO: cnt_val = '0;
      NSEL_ONE:  cnt_val = SAT_W'(1);
      NSEL_CNT:  cnt_val = SAT_W'(cnt);
      NSEL_LEN:  cnt_val = SAT_W'(len);
      default:   cnt_val = '0;
    endcase
    erase_val = (cnt_val > SAT_W'(ERASE_MAX)) ? ERASE_MAX : cnt_val[ERASE_W-1:0];
    case (cmd.char_sel)
      CSEL_ZERO: char_val = '0;
      CSEL_IN:   char_val = cur.rx_char;
      CSEL_RD:   char_val = rd_data;
      default:   char_val = '0;
    endcase
  end

  // Pending result, held until the output register frees up.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.kind        <= cmd.res_kind;
      res.out_char    <= char_val;
      res.erase_count <= erase_val;
      res.line_end    <= cmd.res_end;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid_r <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_r <= res;
    end
  end

  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

  // Status toward the controller.
  always_comb begin
    status.opcode     = cur.opcode;
    status.is_cr      = (cur.rx_char == CH_CR);
    status.is_bs      = (cur.rx_char == CH_BS) || (cur.rx_char == CH_DEL);
    status.is_werase  = (cur.rx_char == CH_WERASE);
    status.is_kill    = (cur.rx_char == CH_KILL);
    status.line_ready = line_ready;
    status.len_zero   = (len == '0);
    status.len_one    = (len == LEN_W'(1));
    status.full       = (len >= LEN_W'(RING_SLOTS - 2));
    status.rd_white   = (rd_data == 8'h20) || ((rd_data >= 8'h09) && (rd_data <= 8'h0D));
    status.out_free   = !rsp_valid_r || !rsp_stall;
  end

  // Both pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rp <= LAST_SLOT) && (wp <= LAST_SLOT))
    else $error("ring pointer out of range");

  // A result never overwrites one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid_r || !rsp_stall))
    else $error("output register overwritten");

  // While a finished line is pending the typed line does not move.
  a_line_frozen: assert property (@(posedge clk) disable iff (rst)
    line_ready |=> $stable(wp))
    else $error("write pointer moved with a line pending");

endmodule

>>> rtl/core/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl: sequencing state machine of the serial line editor
// Decodes each request word, steps the word erase loop over the store,
// and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RDATA = 6'b000100,
    S_WREAD = 6'b001000,
    S_WTEST = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.char_sel = CSEL_ZERO;
    cmd.cnt_sel  = NSEL_ZERO;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_load = 1'b1;
        state_next   = S_EMIT;
        if (status.opcode == OP_READ) begin
          if (!status.line_ready || status.len_zero) begin
            cmd.res_kind = KIND_NOTREADY;
          end else begin
            cmd.res_load = 1'b0;
            cmd.rd_en    = 1'b1;
            state_next   = S_RDATA;
          end
        end else if (status.line_ready) begin
          cmd.res_kind = KIND_DROP;
        end else if (status.is_cr) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_lf     = 1'b1;
          cmd.set_ready = 1'b1;
          cmd.res_kind  = KIND_NEWLINE;
        end else if (status.is_bs) begin
          if (status.len_zero) begin
            cmd.res_kind = KIND_BELL;
          end else begin
            cmd.wp_dec   = 1'b1;
            cmd.res_kind = KIND_ERASE;
            cmd.cnt_sel  = NSEL_ONE;
          end
        end else if (status.is_werase) begin
          cmd.res_load = 1'b0;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_WREAD;
        end else if (status.is_kill) begin
          cmd.wp_to_rp = 1'b1;
          cmd.res_kind = KIND_ERASE;
          cmd.cnt_sel  = NSEL_LEN;
        end else if (status.full) begin
          cmd.res_kind = KIND_BELL;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.res_kind = KIND_ECHO;
          cmd.char_sel = CSEL_IN;
        end
      end
      S_RDATA: begin
        // The byte at the read pointer is now in the read register.
        cmd.res_load    = 1'b1;
        cmd.res_kind    = KIND_DATA;
        cmd.char_sel    = CSEL_RD;
        cmd.res_end     = status.len_one;
        cmd.rp_inc      = 1'b1;
        cmd.clear_ready = status.len_one;
        state_next      = S_EMIT;
      end
      S_WREAD: begin
        // Fetch the character just before the cursor, or finish on an empty line.
        if (status.len_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_ERASE;
          cmd.cnt_sel  = NSEL_CNT;
          state_next   = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next  = S_WTEST;
        end
      end
      S_WTEST: begin
        // Stop at whitespace, otherwise erase it and look one further back.
        if (status.rd_white) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_ERASE;
          cmd.cnt_sel  = NSEL_CNT;
          state_next   = S_EMIT;
        end else begin
          cmd.wp_dec  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_WREAD;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
